// File: rtl/rational_reduce_top_macros.svh
// Assertion macros shared by the rational reduction block.
`ifndef RATIONAL_REDUCE_TOP_MACROS_SVH
`define RATIONAL_REDUCE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define RR_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled during reset.
`define RR_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/rr_pkg.sv
// Shared constants and controller/datapath types for the rational reduction block.
`timescale 1ns / 1ps

package rr_pkg;

   localparam int FIELD_W = 32;

   localparam logic [1:0] OPSEL_GCD = 2'd0;
   localparam logic [1:0] OPSEL_QN  = 2'd1;
   localparam logic [1:0] OPSEL_QD  = 2'd2;

   typedef struct packed {
      logic       load;
      logic       div_start;
      logic [1:0] div_sel;
      logic       gcd_step;
      logic       capture_qn;
      logic       capture_qd;
      logic       out_load;
   } rr_cmd_type;

   typedef struct packed {
      logic den_zero;
      logic div_done;
      logic rem_zero;
   } rr_status_type;

endpackage

// File: rtl/rr_req_if.sv
// Valid/ready channel interface carrying one fraction to be reduced.
`timescale 1ns / 1ps

interface rr_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [rr_pkg::FIELD_W-1:0]  numerator_in;
   logic signed [rr_pkg::FIELD_W-1:0]  denominator_in;

   modport source (output valid, output numerator_in, output denominator_in, input ready);
   modport sink (input valid, input numerator_in, input denominator_in, output ready);
endinterface

// File: rtl/rr_rsp_if.sv
// Valid/ready channel interface carrying one reduced fraction.
`timescale 1ns / 1ps

interface rr_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [rr_pkg::FIELD_W-1:0]  numerator_out;
   logic signed [rr_pkg::FIELD_W-1:0]  denominator_out;
   logic                               valid_res;
   logic                               overflow;

   modport source (output valid, output numerator_out, output denominator_out,
                   output valid_res, output overflow, input ready);
   modport sink (input valid, input numerator_out, input denominator_out,
                 input valid_res, input overflow, output ready);
endinterface

// File: rtl/rr_divider.sv
// Restoring unsigned divider producing one quotient bit per cycle.
`timescale 1ns / 1ps

module rr_divider #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);

   localparam int CNT_W = $clog2(WIDTH);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] dvs_ff, dvs_in;
   logic [WIDTH:0]   rem_sh;
   logic [WIDTH:0]   diff;
   logic             ge;

   assign rem_sh = {rem_ff, quo_ff[WIDTH-1]};
   assign diff   = rem_sh - {1'b0, dvs_ff};
   assign ge     = ~diff[WIDTH];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(WIDTH - 1);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
         quo_in = {quo_ff[WIDTH-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: rtl/rr_ctrl.sv
// Sequencing state machine for the rational reduction block.
`timescale 1ns / 1ps
`include "rational_reduce_top_macros.svh"

module rr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rr_pkg::rr_status_type status,
   output rr_pkg::rr_cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_CHECK     = 4'd1;
   localparam logic [3:0] ST_GCD_START = 4'd2;
   localparam logic [3:0] ST_GCD_WAIT  = 4'd3;
   localparam logic [3:0] ST_QN_START  = 4'd4;
   localparam logic [3:0] ST_QN_WAIT   = 4'd5;
   localparam logic [3:0] ST_QD_START  = 4'd6;
   localparam logic [3:0] ST_QD_WAIT   = 4'd7;
   localparam logic [3:0] ST_FINISH    = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.div_sel = rr_pkg::OPSEL_GCD;
      req_ready   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = status.den_zero ? ST_FINISH : ST_GCD_START;
         end
         ST_GCD_START: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = rr_pkg::OPSEL_GCD;
            state_in      = ST_GCD_WAIT;
         end
         ST_GCD_WAIT: begin
            if (status.div_done) begin
               cmd.gcd_step = 1'b1;
               state_in     = status.rem_zero ? ST_QN_START : ST_GCD_START;
            end
         end
         ST_QN_START: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = rr_pkg::OPSEL_QN;
            state_in      = ST_QN_WAIT;
         end
         ST_QN_WAIT: begin
            if (status.div_done) begin
               cmd.capture_qn = 1'b1;
               state_in       = ST_QD_START;
            end
         end
         ST_QD_START: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = rr_pkg::OPSEL_QD;
            state_in      = ST_QD_WAIT;
         end
         ST_QD_WAIT: begin
            if (status.div_done) begin
               cmd.capture_qd = 1'b1;
               state_in       = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `RR_ASSERT_IMP(a_done_while_waiting, status.div_done, state_ff == ST_GCD_WAIT || state_ff == ST_QN_WAIT || state_ff == ST_QD_WAIT, "divider finished outside a wait state")
   `RR_ASSERT_IMP(a_result_slot_free, cmd.out_load, !rsp_valid_ff || rsp_ready, "result loaded over an untaken transaction")
   `RR_ASSERT_NXT(a_accept_to_check, req_valid && req_ready, state_ff == ST_CHECK, "accepted transaction not followed by the check state")

endmodule

// File: rtl/rr_dpath.sv
// Operand, Euclid and result registers around the shared divider.
`timescale 1ns / 1ps

module rr_dpath #(
   parameter int WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rr_pkg::rr_cmd_type                  cmd,
   output rr_pkg::rr_status_type               status,
   input  logic signed [rr_pkg::FIELD_W-1:0]   numerator_in,
   input  logic signed [rr_pkg::FIELD_W-1:0]   denominator_in,
   output logic signed [rr_pkg::FIELD_W-1:0]   numerator_out,
   output logic signed [rr_pkg::FIELD_W-1:0]   denominator_out,
   output logic                                valid_res,
   output logic                                overflow
);

   localparam logic [WIDTH-1:0] WSIGN = {1'b1, {(WIDTH-1){1'b0}}};

   logic signed [WIDTH-1:0]          n_ff, d_ff;
   logic [WIDTH-1:0]                 a_ff, b_ff, qn_ff, qd_ff;
   logic signed [rr_pkg::FIELD_W-1:0] num_out_ff, num_out_in;
   logic signed [rr_pkg::FIELD_W-1:0] den_out_ff, den_out_in;
   logic                             vres_ff, vres_in;
   logic                             ovf_ff, ovf_in;

   logic                    n_neg, d_neg, r_neg, d_zero;
   logic [WIDTH-1:0]        n_mag, d_mag, rn;
   logic signed [WIDTH-1:0] n_load, d_load;
   logic [WIDTH-1:0]        n_load_mag, d_load_mag;
   logic [WIDTH-1:0]        dividend, divisor;
   logic                    div_done;
   logic [WIDTH-1:0]        quotient, remainder;

   assign n_neg  = n_ff[WIDTH-1];
   assign d_neg  = d_ff[WIDTH-1];
   assign n_mag  = n_neg ? WIDTH'(-n_ff) : WIDTH'(n_ff);
   assign d_mag  = d_neg ? WIDTH'(-d_ff) : WIDTH'(d_ff);
   assign d_zero = (d_ff == '0);

   assign n_load     = WIDTH'(numerator_in);
   assign d_load     = WIDTH'(denominator_in);
   assign n_load_mag = n_load[WIDTH-1] ? WIDTH'(-n_load) : WIDTH'(n_load);
   assign d_load_mag = d_load[WIDTH-1] ? WIDTH'(-d_load) : WIDTH'(d_load);

   always_comb begin
      case (cmd.div_sel)
         rr_pkg::OPSEL_GCD: begin
            dividend = a_ff;
            divisor  = b_ff;
         end
         rr_pkg::OPSEL_QN: begin
            dividend = n_mag;
            divisor  = a_ff;
         end
         rr_pkg::OPSEL_QD: begin
            dividend = d_mag;
            divisor  = a_ff;
         end
         default: begin
            dividend = a_ff;
            divisor  = b_ff;
         end
      endcase
   end

   rr_divider #(
      .WIDTH (WIDTH)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (dividend),
      .divisor   (divisor),
      .done      (div_done),
      .quotient  (quotient),
      .remainder (remainder)
   );

   assign status.den_zero = d_zero;
   assign status.div_done = div_done;
   assign status.rem_zero = (remainder == '0);

   assign r_neg = (n_neg != d_neg) && (qn_ff != '0);
   assign rn    = r_neg ? (~qn_ff + 1'b1) : qn_ff;

   always_comb begin
      if (d_zero) begin
         num_out_in = rr_pkg::FIELD_W'(n_ff);
         den_out_in = rr_pkg::FIELD_W'(d_ff);
         vres_in    = 1'b0;
         ovf_in     = 1'b0;
      end else begin
         num_out_in = rr_pkg::FIELD_W'(signed'(rn));
         den_out_in = rr_pkg::FIELD_W'(signed'(qd_ff));
         vres_in    = 1'b1;
         ovf_in     = (!r_neg && qn_ff == WSIGN) || (qd_ff == WSIGN);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n_ff <= n_load;
         d_ff <= d_load;
         a_ff <= n_load_mag;
         b_ff <= d_load_mag;
      end else if (cmd.gcd_step) begin
         a_ff <= b_ff;
         b_ff <= remainder;
      end
      if (cmd.capture_qn) begin
         qn_ff <= quotient;
      end
      if (cmd.capture_qd) begin
         qd_ff <= quotient;
      end
      if (cmd.out_load) begin
         num_out_ff <= num_out_in;
         den_out_ff <= den_out_in;
         vres_ff    <= vres_in;
         ovf_ff     <= ovf_in;
      end
   end

   assign numerator_out   = num_out_ff;
   assign denominator_out = den_out_ff;
   assign valid_res       = vres_ff;
   assign overflow        = ovf_ff;

endmodule

// File: rtl/rational_reduce_top.sv
// Top level of the rational reduction block: controller, datapath and channel ports.
`timescale 1ns / 1ps

// Reduces a signed fraction to lowest terms, one transaction at a time. A zero
// denominator skips the divider and passes the operands through with valid_res
// low. Otherwise the Euclid remainders and the two final quotients all run on
// one shared restoring divider that yields one quotient bit per cycle: one
// division per Euclid step (at most about 1.44 * WIDTH steps), then one per
// quotient. A finished result waits in an output register; the next transaction
// is accepted while it waits, and its own result is held back until the earlier
// one has been taken.

module rational_reduce_top #(
   parameter int WIDTH = 32
) (
   input  logic     clock,
   input  logic     reset,
   rr_req_if.sink   req_chan,
   rr_rsp_if.source rsp_chan
);

   rr_pkg::rr_cmd_type    cmd;
   rr_pkg::rr_status_type status;

   rr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rr_dpath #(
      .WIDTH (WIDTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .numerator_in    (req_chan.numerator_in),
      .denominator_in  (req_chan.denominator_in),
      .numerator_out   (rsp_chan.numerator_out),
      .denominator_out (rsp_chan.denominator_out),
      .valid_res       (rsp_chan.valid_res),
      .overflow        (rsp_chan.overflow)
   );

endmodule

// File: tb/rational_reduce_top_test.sv
// Self-checking testbench for rational_reduce_top: directed corner fractions, then random ones.
`timescale 1ns / 1ps

module rational_reduce_top_test;

   localparam int W            = rr_pkg::FIELD_W;
   localparam int RANDOM_ITEMS = 730;
   localparam int DRAIN_CYCLES = 2000;
   localparam int CYCLE_LIMIT  = 6_000_000;
   localparam int REPORT_LIMIT = 10;

   localparam logic signed [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0]        SIGN_BIT = {1'b1, {(W-1){1'b0}}};

   typedef struct packed {
      logic signed [W-1:0] numerator;
      logic signed [W-1:0] denominator;
      logic                valid_res;
      logic                overflow;
   } fraction_type;

   typedef struct packed {
      logic signed [W-1:0] num_in;
      logic signed [W-1:0] den_in;
      logic                typed;
      fraction_type        result;
   } stim_row_type;

   logic clock;
   logic reset;
   bit   quiet_phase = 1'b0;
   int   fault_count = 0;
   int   cycle_count = 0;

   fraction_type pending_fractions[$];

   logic signed [W-1:0] corner_values [0:7] = '{
      '0, 1, -1, MOST_NEG, MOST_POS, MOST_NEG + 1, 2, -2
   };

   stim_row_type directed_rows [0:23] = '{
      '{ 0,         0,         1'b1, '{ 0,            0,        1'b0, 1'b0}},
      '{ 5,         0,         1'b1, '{ 5,            0,        1'b0, 1'b0}},
      '{ MOST_NEG,  0,         1'b1, '{ MOST_NEG,     0,        1'b0, 1'b0}},
      '{-1,         0,         1'b1, '{-1,            0,        1'b0, 1'b0}},
      '{ 0,         7,         1'b1, '{ 0,            1,        1'b1, 1'b0}},
      '{ 0,        -5,         1'b1, '{ 0,            1,        1'b1, 1'b0}},
      '{ 0,         MOST_NEG,  1'b1, '{ 0,            1,        1'b1, 1'b0}},
      '{ 1,         1,         1'b1, '{ 1,            1,        1'b1, 1'b0}},
      '{-1,        -1,         1'b1, '{ 1,            1,        1'b1, 1'b0}},
      '{ MOST_POS, -1,         1'b1, '{ MOST_NEG + 1, 1,        1'b1, 1'b0}},
      '{ MOST_NEG,  1,         1'b1, '{ MOST_NEG,     1,        1'b1, 1'b0}},
      '{ MOST_NEG, -1,         1'b1, '{ MOST_NEG,     1,        1'b1, 1'b1}},
      '{ 1,         MOST_NEG,  1'b1, '{-1,            MOST_NEG, 1'b1, 1'b1}},
      '{ MOST_POS,  MOST_NEG,  1'b1, '{ MOST_NEG + 1, MOST_NEG, 1'b1, 1'b1}},
      '{ MOST_NEG,  MOST_NEG,  1'b1, '{ 1,            1,        1'b1, 1'b0}},
      '{ MOST_POS,  MOST_POS,  1'b1, '{ 1,            1,        1'b1, 1'b0}},
      '{-3,         MOST_NEG,  1'b0, '0},
      '{ MOST_NEG, -3,         1'b0, '0},
      '{ 6,        -4,         1'b0, '0},
      '{ 12,        18,        1'b0, '0},
      '{ 1836311903, 1134903170, 1'b0, '0},
      '{-1134903170, 701408733,  1'b0, '0},
      '{ MOST_NEG,  6,         1'b0, '0},
      '{ MOST_POS,  2,         1'b0, '0}
   };

   rr_req_if req_bus ();
   rr_rsp_if rsp_bus ();

   rational_reduce_top #(
      .WIDTH(W)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus.sink),
      .rsp_chan (rsp_bus.source)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // The sign is applied after the magnitudes are divided, so only a positive
   // result of exactly 2^(W-1) can wrap.
   function automatic fraction_type reduce_fraction(input logic signed [W-1:0] num,
                                                    input logic signed [W-1:0] den);
      fraction_type r;
      logic [W-1:0] mag_n, mag_d, a, b, t, quo_n, quo_d;
      logic         neg_n, neg_d;
      r.numerator   = num;
      r.denominator = den;
      r.valid_res   = 1'b0;
      r.overflow    = 1'b0;
      if (den == '0) begin
         return r;
      end
      neg_n = num[W-1];
      neg_d = den[W-1];
      mag_n = neg_n ? -num : num;
      mag_d = neg_d ? -den : den;
      a = mag_n;
      b = mag_d;
      while (b != '0) begin
         t = a % b;
         a = b;
         b = t;
      end
      quo_n = mag_n / a;
      quo_d = mag_d / a;
      r.valid_res = 1'b1;
      if (neg_n != neg_d && quo_n != '0) begin
         r.numerator = -quo_n;
      end else begin
         r.numerator = quo_n;
         if (quo_n == SIGN_BIT) r.overflow = 1'b1;
      end
      r.denominator = quo_d;
      if (quo_d == SIGN_BIT) r.overflow = 1'b1;
      return r;
   endfunction

   // Valid is left high between back-to-back transactions so that it never
   // receives two assignments in one time step.
   task automatic send_fraction(input logic signed [W-1:0] num,
                                input logic signed [W-1:0] den,
                                input fraction_type want);
      int gap;
      gap = quiet_phase ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.numerator_in   <= num;
      req_bus.denominator_in <= den;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      pending_fractions.push_back(want);
   endtask

   task automatic hold_until_drained();
      req_bus.valid <= 1'b0;
      while (pending_fractions.size() != 0) @(posedge clock);
   endtask

   initial begin
      fraction_type        want;
      logic signed [W-1:0] n, d;
      int unsigned         a, b, f;
      req_bus.valid          <= 1'b0;
      req_bus.numerator_in   <= '0;
      req_bus.denominator_in <= '0;
      reset <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         n = directed_rows[i].num_in;
         d = directed_rows[i].den_in;
         want = directed_rows[i].typed ? directed_rows[i].result : reduce_fraction(n, d);
         send_fraction(n, d, want);
      end
      hold_until_drained();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         quiet_phase = ((i / 64) % 3) == 1;
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               n = $urandom;
               d = $urandom;
            end
            3, 4, 5: begin
               a = $urandom_range(0, 1 << 15);
               b = $urandom_range(1, 1 << 15);
               f = $urandom_range(1, 1 << 15);
               n = a * f;
               d = b * f;
               if ($urandom_range(0, 1)) n = -n;
               if ($urandom_range(0, 1)) d = -d;
            end
            6: begin
               n = corner_values[$urandom_range(0, 7)];
               d = corner_values[$urandom_range(0, 7)];
            end
            7: begin
               n = $urandom;
               d = '0;
            end
            8: begin
               n = $urandom;
               d = n + $urandom_range(1, 5);
            end
            default: begin
               n = '0;
               d = '0;
               n[$urandom_range(0, W - 1)] = 1'b1;
               d[$urandom_range(0, W - 1)] = 1'b1;
               if ($urandom_range(0, 1)) n = -n;
               if ($urandom_range(0, 1)) d = -d;
            end
         endcase
         if (i == RANDOM_ITEMS / 2) hold_until_drained();
         send_fraction(n, d, reduce_fraction(n, d));
      end
      req_bus.valid <= 1'b0;

      while (pending_fractions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0 && pending_fractions.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      int           stall;
      fraction_type want;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = quiet_phase ? 0 : $urandom_range(0, 7);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (reset || rsp_bus.valid !== 1'b1) @(posedge clock);
         if (pending_fractions.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
               $display("unexpected transaction: %0d/%0d valid_res %b overflow %b",
                        rsp_bus.numerator_out, rsp_bus.denominator_out,
                        rsp_bus.valid_res, rsp_bus.overflow);
         end else begin
            want = pending_fractions.pop_front();
            if (rsp_bus.numerator_out !== want.numerator
                || rsp_bus.denominator_out !== want.denominator
                || rsp_bus.valid_res !== want.valid_res
                || rsp_bus.overflow !== want.overflow) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("mismatch: expected %0d/%0d v%b o%b, got %0d/%0d v%b o%b",
                           want.numerator, want.denominator, want.valid_res,
                           want.overflow, rsp_bus.numerator_out,
                           rsp_bus.denominator_out, rsp_bus.valid_res,
                           rsp_bus.overflow);
            end
         end
      end
   end

endmodule

// File: rational_reduce_top.f
+incdir+rtl
rtl/rr_pkg.sv
rtl/rr_req_if.sv
rtl/rr_rsp_if.sv
rtl/rr_divider.sv
rtl/rr_ctrl.sv
rtl/rr_dpath.sv
rtl/rational_reduce_top.sv
tb/rational_reduce_top_test.sv
